@@ rtl/core/qpd_pkg.sv @@
// shared types, character codes and helpers of the quoted-printable decoder
package qpd_pkg;

  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  // register index in the configuration space
  localparam logic [0:0] REG_UNDERSCORE = 1'b0;

  localparam logic [7:0] CHR_EQ    = 8'h3D;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_US    = 8'h5F;
  localparam logic [7:0] CHR_SPACE = 8'h20;

  typedef enum logic [3:0] {
    PH_PLAIN = 4'b0001,
    PH_EQ    = 4'b0010,
    PH_HIGH  = 4'b0100,
    PH_CR    = 4'b1000
  } qpd_phase_e;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
    logic       trunc;
  } qpd_result_t;

  // hex digit value, anything else counts as zero
  function automatic logic [3:0] hex_value(input logic [7:0] b);
    logic [3:0] v;
    v = 4'h0;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      v = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      v = 4'(b - 8'h37);
    end
    return v;
  endfunction

endpackage

@@ rtl/core/qpd_apb_regs.sv @@
// apb configuration register of the quoted-printable decoder
module qpd_apb_regs import qpd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output logic                underscore_o
);

  logic underscore_q, underscore_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_UNDERSCORE);

  always_comb begin
    underscore_d = underscore_q;
    if (wr_en) begin
      underscore_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      underscore_q <= 1'b0;
    end else begin
      underscore_q <= underscore_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_UNDERSCORE) begin
      prdata = {{(ApbDataW-1){1'b0}}, underscore_q};
    end
  end

  assign underscore_o = underscore_q;

endmodule

@@ rtl/core/qpd_decode.sv @@
// input register, escape state and decode logic
module qpd_decode import qpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  input  logic        underscore_i,
  input  logic        res_ready_i,
  output logic        res_valid_o,
  output qpd_result_t res_o
);

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  qpd_phase_e phase_q, phase_d;
  logic [3:0] nibble_q, nibble_d;
  logic       advance;
  logic       load;

  qpd_phase_e eff_phase;
  qpd_phase_e next_phase;
  logic       out_v;
  logic [7:0] out_b;

  assign advance     = in_valid_q && res_ready_i;
  assign in_ready_o  = !in_valid_q || res_ready_i;
  assign load        = in_valid_i && in_ready_o;
  assign res_valid_o = in_valid_q;

  always_comb begin
    in_valid_d = in_valid_q;
    if (load) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      in_byte_q <= in_byte_i;
      in_last_q <= in_last_i;
    end
  end

  always_comb begin
    out_v      = 1'b0;
    out_b      = 8'h00;
    nibble_d   = nibble_q;
    // a byte after "=" cr that is not lf is decoded in the plain phase
    eff_phase  = (phase_q == PH_CR) ? PH_PLAIN : phase_q;
    next_phase = eff_phase;
    if (phase_q == PH_CR && in_byte_q == CHR_LF) begin
      next_phase = PH_PLAIN;
    end else begin
      case (eff_phase)
        PH_PLAIN: begin
          if (in_byte_q == CHR_EQ) begin
            next_phase = PH_EQ;
          end else begin
            out_v = 1'b1;
            out_b = in_byte_q;
          end
        end
        PH_EQ: begin
          if (in_byte_q == CHR_CR) begin
            next_phase = PH_CR;
          end else if (in_byte_q == CHR_LF) begin
            next_phase = PH_PLAIN;
          end else begin
            nibble_d   = hex_value(in_byte_q);
            next_phase = PH_HIGH;
          end
        end
        PH_HIGH: begin
          out_v      = 1'b1;
          out_b      = {nibble_q, hex_value(in_byte_q)};
          next_phase = PH_PLAIN;
        end
        default: begin
          next_phase = PH_PLAIN;
        end
      endcase
    end

    if (out_v && underscore_i && out_b == CHR_US) begin
      out_b = CHR_SPACE;
    end

    res_o.valid = out_v;
    res_o.data  = out_b;
    res_o.last  = in_last_q;
    res_o.trunc = in_last_q && (next_phase == PH_EQ || next_phase == PH_HIGH);

    phase_d = next_phase;
    if (in_last_q) begin
      phase_d  = PH_PLAIN;
      nibble_d = 4'h0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_PLAIN;
      nibble_q <= 4'h0;
    end else if (advance) begin
      phase_q  <= phase_d;
      nibble_q <= nibble_d;
    end
  end

  a_trunc_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && res_o.trunc) |-> res_o.last)
    else $error("truncated flag without last");

  a_no_data_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !res_o.valid) |-> (res_o.data == 8'h00))
    else $error("data nonzero on empty result");

  a_last_clears_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_last_q) |=> (phase_q == PH_PLAIN && nibble_q == 4'h0))
    else $error("state not cleared after last item");

endmodule

@@ rtl/core/qpd_out_stage.sv @@
// result register toward the output stream
module qpd_out_stage import qpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        res_valid_i,
  input  qpd_result_t res_i,
  output logic        res_ready_o,
  output logic        m_valid_o,
  input  logic        m_ready_i,
  output qpd_result_t m_res_o
);

  logic        valid_q, valid_d;
  qpd_result_t res_q;

  assign res_ready_o = !valid_q || m_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (res_ready_o) begin
      valid_d = res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign m_valid_o = valid_q;
  assign m_res_o   = res_q;

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_ready_o && res_valid_i) |=> valid_q)
    else $error("loaded result not presented");

  a_stall_keeps_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !m_ready_i) |=> (valid_q && $stable(res_q)))
    else $error("stalled result lost or changed");

endmodule

@@ rtl/core/quoted_printable_decoder_top.sv @@
// top level of the quoted-printable stream decoder
// Decodes quoted-printable text one byte per item. A plain byte passes through, "=" and
// two hex digits give one byte (a non-hex digit counts as zero), and "=" followed by cr,
// lf or cr lf is a soft line break that gives an empty result. Every input item gives
// exactly one result item: tuser[0] says whether tdata holds a decoded byte, tlast
// copies the input tlast, and tuser[1] flags a stream that ended inside an unfinished
// escape. Register 0 at address 0, bit 0, turns each output underscore into a space for
// header Q-word text; write it only while the block is idle. One item is accepted every
// clock cycle while the output is not stalled; each item passes through the input register
// and then the result register, with decode and escape state update between them.
module quoted_printable_decoder_top import qpd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] in_byte
  input  logic                s_axis_tlast,   // in_last
  // output stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,   // [7:0] out_byte
  output logic                m_axis_tlast,   // out_last
  output logic [1:0]          m_axis_tuser,   // [0] out_valid, [1] truncated
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  logic        underscore;
  logic        res_valid;
  logic        res_ready;
  qpd_result_t res;
  qpd_result_t m_res;

  // configuration register
  qpd_apb_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .underscore_o(underscore)
  );

  // input register and decode, state advances when the item moves on
  qpd_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .underscore_i(underscore),
    .res_ready_i (res_ready),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result register, holds a waiting result and stalls the input side until it is taken
  qpd_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(res_valid),
    .res_i      (res),
    .res_ready_o(res_ready),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_res_o    (m_res)
  );

  assign m_axis_tdata = m_res.data;
  assign m_axis_tlast = m_res.last;
  assign m_axis_tuser = {m_res.trunc, m_res.valid};

endmodule

@@ tb/sv/quoted_printable_decoder_top_test.sv @@
// self-checking testbench for the quoted-printable stream decoder
module quoted_printable_decoder_top_test;
  import qpd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // cycles without any handshake before the run is declared hung; covers the long
  // receiver hold-off plus sender gaps with plenty of margin
  localparam int unsigned StallLimit = 3000;
  // results accepted before the receiver goes quiet once, and for how long
  localparam int unsigned HoldAfter  = 500;
  localparam int unsigned HoldCycles = 400;
  // random bytes per configuration phase
  localparam int unsigned PhaseItems = 280;
  localparam int unsigned MaxPrints  = 50;

  // one encoded input item
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } enc_item_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;  // [7:0] in_byte
  logic                s_axis_tlast  = 1'b0;  // in_last
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;  // [7:0] out_byte
  logic                m_axis_tlast;  // out_last
  logic [1:0]          m_axis_tuser;  // [0] out_valid, [1] truncated
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [ApbAddrW-1:0] paddr   = '0;
  logic [ApbDataW-1:0] pwdata  = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  // bytes waiting to be offered, and decoded results waiting to come out
  enc_item_t   encoded_bytes[$];
  qpd_result_t expected_decodes[$];

  // decoder state as the testbench sees it
  qpd_phase_e  qp_phase      = PH_PLAIN;
  logic [3:0]  qp_high_digit = 4'h0;
  logic        qp_us_mode    = 1'b0;

  int unsigned error_count   = 0;
  int unsigned results_count = 0;

  quoted_printable_decoder_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // value of one hex digit in either case; anything else decodes as zero
  function automatic logic [3:0] digit_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'h0;
    case (c) inside
      [8'h30:8'h39]: v = c[3:0];
      [8'h41:8'h46], [8'h61:8'h66]: v = c[3:0] + 4'd9;
      default: v = 4'h0;
    endcase
    return v;
  endfunction

  // decodes one accepted byte and advances the escape state
  function automatic qpd_result_t qp_decode_byte(input logic [7:0] b, input logic last);
    qpd_result_t res;
    logic        swallowed;
    res       = '0;
    res.last  = last;
    swallowed = 1'b0;
    // after "=" cr an lf completes the soft break, anything else is decoded afresh
    if (qp_phase == PH_CR) begin
      qp_phase  = PH_PLAIN;
      swallowed = (b == CHR_LF);
    end
    if (!swallowed) begin
      case (qp_phase)
        PH_PLAIN: begin
          if (b == CHR_EQ) begin
            qp_phase = PH_EQ;
          end else begin
            res.valid = 1'b1;
            res.data  = b;
          end
        end
        PH_EQ: begin
          if (b == CHR_CR) begin
            qp_phase = PH_CR;
          end else if (b == CHR_LF) begin
            qp_phase = PH_PLAIN;
          end else begin
            qp_high_digit = digit_value(b);
            qp_phase      = PH_HIGH;
          end
        end
        default: begin
          res.valid = 1'b1;
          res.data  = {qp_high_digit, digit_value(b)};
          qp_phase  = PH_PLAIN;
        end
      endcase
    end
    // q-word mode also rewrites underscores that came out of an escape
    if (res.valid && qp_us_mode && res.data == CHR_US) begin
      res.data = CHR_SPACE;
    end
    // end of stream: an open escape is dropped and flagged, state starts over
    if (last) begin
      res.trunc     = (qp_phase == PH_EQ || qp_phase == PH_HIGH);
      qp_phase      = PH_PLAIN;
      qp_high_digit = 4'h0;
    end
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input logic [7:0] got,
                               input logic [7:0] want);
    if (error_count < MaxPrints) begin
      $display("%0t: %s on result %0d: got %h, want %h", $realtime, what, results_count,
               got, want);
    end
    error_count++;
  endtask

  // sender: bursts of random length, random gaps, data held while stalled
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        void'(encoded_bytes.pop_front());
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // item still on offer, keep it steady
      end else if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (encoded_bytes.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= encoded_bytes[0].data;
        s_axis_tlast  <= encoded_bytes[0].last;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stretches with different stall rates, one long hold-off so that the
  // block fills up and pushes back on its input
  int unsigned results_seen = 0;
  int unsigned hold_left    = 0;
  int unsigned stretch_left = 0;
  int unsigned stall_pct    = 0;
  bit          hold_done    = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && results_seen >= HoldAfter) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
        m_axis_tready <= 1'b0;
      end else begin
        if (stretch_left == 0) begin
          stretch_left = $urandom_range(10, 120);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 60;
            default: stall_pct = 90;
          endcase
        end else begin
          stretch_left--;
        end
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // monitor: checks results against the oldest expectation, then predicts the
  // result of any byte taken at this edge (latency keeps the two apart)
  always @(posedge clk_i) begin
    qpd_result_t got;
    qpd_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.valid = m_axis_tuser[0];
        got.data  = m_axis_tdata;
        got.last  = m_axis_tlast;
        got.trunc = m_axis_tuser[1];
        if (expected_decodes.size() == 0) begin
          flag_mismatch("result with nothing expected", got.data, 8'h00);
        end else begin
          want = expected_decodes.pop_front();
          if (got.valid !== want.valid) begin
            flag_mismatch("out_valid", 8'(got.valid), 8'(want.valid));
          end
          if (got.data !== want.data) flag_mismatch("out_byte", got.data, want.data);
          if (got.last !== want.last) begin
            flag_mismatch("out_last", 8'(got.last), 8'(want.last));
          end
          if (got.trunc !== want.trunc) begin
            flag_mismatch("truncated", 8'(got.trunc), 8'(want.trunc));
          end
        end
        results_count++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_decodes.push_back(qp_decode_byte(s_axis_tdata, s_axis_tlast));
      end
    end
  end

  // watchdog: any handshake on either stream or the config port counts as progress
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("timeout: no handshake for %0d cycles", StallLimit);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // queue filling happens at the falling edge, away from the sender's edge
  task automatic push_byte(input logic [7:0] b, input logic last);
    encoded_bytes.push_back('{data: b, last: last});
  endtask

  task automatic push_text(input string s, input bit ends_stream);
    for (int i = 0; i < s.len(); i++) begin
      push_byte(s[i], ends_stream && (i == s.len() - 1));
    end
  endtask

  // wait until every byte is taken and every result checked
  task automatic drain();
    do @(negedge clk_i);
    while (encoded_bytes.size() != 0 || expected_decodes.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_us_mode(input logic [ApbDataW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'(4 * REG_UNDERSCORE);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // only bit 0 is stored; the block is idle so the predictor can switch now
    qp_us_mode = value[0];
    @(negedge clk_i);
  endtask

  // random streams: mostly well-formed text with escapes and soft breaks, some
  // broken escapes and raw noise, and some streams that stop inside an escape
  task automatic fill_random_streams(input int unsigned target);
    string       hexdigits;
    logic [7:0]  text[$];
    logic [7:0]  b;
    int unsigned count;
    int unsigned tokens;
    hexdigits = "0123456789abcdefABCDEF";
    count     = 0;
    while (count < target) begin
      text.delete();
      tokens = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      for (int t = 0; t < tokens; t++) begin
        case ($urandom_range(0, 99)) inside
          [0:44]: begin
            b = 8'($urandom_range(0, 255));
            text.push_back((b == CHR_EQ) ? CHR_US : b);
          end
          [45:59]: begin
            text.push_back(CHR_EQ);
            text.push_back(hexdigits[$urandom_range(0, 21)]);
            text.push_back(hexdigits[$urandom_range(0, 21)]);
          end
          [60:69]: begin
            text.push_back(CHR_EQ);
            case ($urandom_range(0, 2))
              0: begin
                text.push_back(CHR_CR);
                text.push_back(CHR_LF);
              end
              1: text.push_back(CHR_LF);
              default: text.push_back(CHR_CR);
            endcase
          end
          [70:77]: begin
            if ($urandom_range(0, 1)) begin
              text.push_back(CHR_US);
            end else begin
              text.push_back(CHR_EQ);
              text.push_back("5");
              text.push_back($urandom_range(0, 1) ? "F" : "f");
            end
          end
          [78:89]: begin
            text.push_back(CHR_EQ);
            text.push_back(8'($urandom_range(0, 255)));
            text.push_back(8'($urandom_range(0, 255)));
          end
          default: text.push_back(8'($urandom_range(0, 255)));
        endcase
      end
      // some streams end after "=", after "=" and one digit, or after "=" cr
      case ($urandom_range(0, 9))
        0: text.push_back(CHR_EQ);
        1: begin
          text.push_back(CHR_EQ);
          text.push_back(hexdigits[$urandom_range(0, 21)]);
        end
        2: begin
          text.push_back(CHR_EQ);
          text.push_back(CHR_CR);
        end
        default: ;
      endcase
      foreach (text[i]) begin
        push_byte(text[i], i == text.size() - 1);
      end
      count += text.size();
    end
  endtask

  initial begin
    logic [ApbDataW-1:0] mode_value;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed, underscore mode at its reset value
    push_text("A", 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    // soft breaks: "=" cr lf, "=" lf
    push_byte(CHR_EQ, 1'b0);
    push_byte(CHR_CR, 1'b0);
    push_byte(CHR_LF, 1'b0);
    push_byte(CHR_EQ, 1'b0);
    push_byte(CHR_LF, 1'b0);
    // lone cr soft break followed by a new escape, then by a plain byte
    push_byte(CHR_EQ, 1'b0);
    push_byte(CHR_CR, 1'b0);
    push_text("=41", 1'b0);
    push_byte(CHR_EQ, 1'b0);
    push_byte(CHR_CR, 1'b0);
    push_text("Q", 1'b0);
    // non-hex digits count as zero; underscores pass unchanged in this mode
    push_text("=zG_=5F", 1'b0);
    // stream ends after "=", after "=" and one digit, and after "=" cr
    push_text("=", 1'b1);
    push_text("=4", 1'b1);
    push_byte(CHR_EQ, 1'b0);
    push_byte(CHR_CR, 1'b1);
    push_text("Z", 1'b1);
    drain();

    // directed, q-word mode: plain and escaped underscores become spaces
    write_us_mode(32'h0000_0001);
    push_text("_=5F=5fa", 1'b1);
    drain();

    // random phases over several register settings, extremes first
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: mode_value = 32'h0000_0000;
        1: mode_value = 32'hFFFF_FFFF;
        2: mode_value = 32'hFFFF_FFFE;
        3: mode_value = 32'h0000_0001;
        default: mode_value = $urandom();
      endcase
      write_us_mode(mode_value);
      fill_random_streams(PhaseItems);
      drain();
    end

    // wait for anything stray to show up
    repeat (10) @(negedge clk_i);
    if (error_count == 0 && expected_decodes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/qpd_pkg.sv
rtl/core/qpd_apb_regs.sv
rtl/core/qpd_decode.sv
rtl/core/qpd_out_stage.sv
rtl/core/quoted_printable_decoder_top.sv
tb/sv/quoted_printable_decoder_top_test.sv
